@@ hdl/assert_macros.svh @@
// assertion helpers for the keystream block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define XSKS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked also during reset
`define XSKS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/xsks_pkg.sv @@
package xsks_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;

  localparam word_t SeedX = 32'd123456789;
  localparam word_t SeedY = 32'd362436069;
  localparam word_t SeedZ = 32'd521288629;

  localparam int unsigned ShiftT = 11;
  localparam int unsigned ShiftW = 19;
  localparam int unsigned ShiftTr = 8;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
  } gen_t;

  // one xorshift128 step
  function automatic gen_t gen_advance(input gen_t g);
    word_t t;
    gen_t  n;
    t   = g.x ^ (g.x << ShiftT);
    n.x = g.y;
    n.y = g.z;
    n.z = g.w;
    n.w = g.w ^ (g.w >> ShiftW) ^ t ^ (t >> ShiftTr);
    return n;
  endfunction

endpackage

@@ hdl/xorshift_keystream_byte_xor_top.sv @@
// xorshift128 keystream byte decryptor
// input channel: in_valid/in_stall carry one encrypted byte per word with
//   in_region_start marking the first byte of a region (reseeds the generator)
// result channel: out_valid/out_stall carry one plain byte per input word,
//   in the same order
// config channel: cfg_valid/cfg_ready write key_seed; cfg_ready is always high;
//   the seed is only used at the next region start
// each accepted byte's result is registered (skid register while stalled)
// throughput: one byte per cycle unless stalled; generator step, refill
//   and xor all happen in the accepting cycle, into result or skid register
// a two-entry output stage (result register plus skid register) keeps
//   in_stall registered; input is stalled only when both entries are full
// reset: synchronous, active low; generator returns to its start values with
//   w = 0, pending key word cleared, seed cleared, output stage emptied
// when the receiver stalls the result holds; one more byte is taken into the
//   skid register, then in_stall rises until the receiver drains
module xorshift_keystream_byte_xor_top
  import xsks_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_region_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_plain_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_key_seed
);

  word_t seed_r;
  gen_t  gen_r, gen_nxt;
  word_t pend_r, pend_nxt;
  byte_t res_nxt;
  byte_t out_byte_r, skid_byte_r;
  logic  out_valid_r, skid_valid_r;
  logic  in_acc, out_take;
  gen_t  gen_base;
  word_t pend_base;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  assign out_valid      = out_valid_r;
  assign out_plain_byte = out_byte_r;

  always_comb begin
    if (in_region_start) begin
      gen_base  = '{x: SeedX, y: SeedY, z: SeedZ, w: seed_r};
      pend_base = '0;
    end else begin
      gen_base  = gen_r;
      pend_base = pend_r;
    end
    gen_nxt = gen_base;
    if (pend_base == '0) begin
      gen_nxt = gen_advance(gen_base);
      pend_base = gen_nxt.w;
    end
    res_nxt  = in_data_byte ^ pend_base[ByteW-1:0];
    pend_nxt = pend_base >> ByteW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= '0;
      gen_r        <= '{x: SeedX, y: SeedY, z: SeedZ, w: '0};
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seed_r <= cfg_key_seed;
      end
      if (in_acc) begin
        gen_r  <= gen_nxt;
        pend_r <= pend_nxt;
      end
      if (!out_valid_r || out_take) begin
        if (skid_valid_r) begin
          out_byte_r   <= skid_byte_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_byte_r  <= res_nxt;
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_byte_r  <= res_nxt;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/xsks_checker.sv @@
`include "assert_macros.svh"

module xsks_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_plain_byte
);

  // output stage never holds a skid word without a result word
  `XSKS_ASSERT(a_stall_needs_out, in_stall |-> out_valid, "in_stall without pending word")

  // stalls only build up from an unaccepted result
  `XSKS_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(out_valid && out_stall && in_valid), "in_stall rose without backpressure")

  // reset empties the output stage
  `XSKS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "output stage not empty after reset")

  // stalled result word stays and holds its byte
  `XSKS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_plain_byte), "stalled result word changed")

endmodule

bind xorshift_keystream_byte_xor_top xsks_checker u_xsks_checker (.*);

@@ verif/xorshift_keystream_byte_xor_top_tb.sv @@
module xorshift_keystream_byte_xor_top_tb;
  import xsks_pkg::*;

  class keystream_scoreboard;
    word_t seed;
    word_t gx, gy, gz, gw;
    word_t pending;
    byte_t plain_q[$];
    int unsigned mismatches;
    bit failed;

    function void clear();
      seed = '0;
      reseed();
      plain_q.delete();
      mismatches = 0;
      failed = 1'b0;
    endfunction

    function void reseed();
      gx = SeedX;
      gy = SeedY;
      gz = SeedZ;
      gw = seed;
      pending = '0;
    endfunction

    function void load_seed(word_t v);
      seed = v;
    endfunction

    function void note_cipher_byte(byte_t data, bit region_start);
      word_t t;
      if (region_start) begin
        reseed();
      end
      if (pending == '0) begin
        t = gx ^ (gx << ShiftT);
        gx = gy;
        gy = gz;
        gz = gw;
        gw = gw ^ (gw >> ShiftW) ^ t ^ (t >> ShiftTr);
        pending = gw;
      end
      plain_q.push_back(data ^ pending[7:0]);
      pending = pending >> 8;
    endfunction

    function void check_plain_byte(byte_t got);
      byte_t want;
      if (plain_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected plain byte %02h", got);
        end
      end else begin
        want = plain_q.pop_front();
        if (want !== got) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) begin
            $display("plain byte mismatch: expected %02h, got %02h", want, got);
          end
        end
      end
    endfunction

    function void check_leftover();
      if (plain_q.size() != 0) begin
        failed = 1'b1;
        $display("%0d plain bytes never arrived", plain_q.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_region_start;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_plain_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_key_seed;

  keystream_scoreboard sb;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;

  xorshift_keystream_byte_xor_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_region_start (in_region_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_plain_byte  (out_plain_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_key_seed    (cfg_key_seed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("Verification failed");
    $finish;
  end

  // receiver stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_plain_byte(out_plain_byte);
      end
      if (in_valid && !in_stall) begin
        sb.note_cipher_byte(in_data_byte, in_region_start);
      end
      if (cfg_valid && cfg_ready) begin
        sb.load_seed(cfg_key_seed);
      end
    end
  end

  task automatic send_byte(input byte_t data, input bit region_start);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_region_start <= region_start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.plain_q.size() != 0);
  endtask

  // block must be idle here
  task automatic write_seed(input word_t v);
    cfg_valid    <= 1'b1;
    cfg_key_seed <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int len;
    int k;
    bit start;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 5) begin
        drain();
        case ($urandom_range(4))
          0: write_seed(32'h0000_0000);
          1: write_seed(32'hFFFF_FFFF);
          2: write_seed(32'h8000_0001);
          default: write_seed($urandom);
        endcase
      end
      len = ($urandom_range(19) == 0) ? $urandom_range(120, 60) : $urandom_range(40, 1);
      for (k = 0; k < len && sent < n_items; k++) begin
        // mostly well-formed regions, some headless ones and stray starts
        start = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
        send_byte(byte_t'($urandom_range(255)), start);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = '0;
    in_region_start = 1'b0;
    cfg_valid       = 1'b0;
    cfg_key_seed    = '0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bytes before any region start run on the reset generator
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);

    drain();
    write_seed(32'hFFFF_FFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h00, 1'b1);

    drain();
    write_seed(32'h0000_0000);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);

    // new seed mid region only takes effect at the next start
    drain();
    write_seed(32'h1234_5678);
    send_byte(8'h9A, 1'b0);
    send_byte(8'hBC, 1'b0);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hF1, 1'b1);
    send_byte(8'h23, 1'b0);

    in_idle_pct   = 22;
    out_stall_pct = 46;
    drain();
    write_seed($urandom);
    run_phase(550);

    in_idle_pct   = 46;
    out_stall_pct = 22;
    drain();
    write_seed(32'hFFFF_FFFF);
    run_phase(550);

    in_idle_pct   = 0;
    out_stall_pct = 0;
    drain();
    write_seed(32'h0000_0000);
    run_phase(550);

    drain();
    repeat (5) @(negedge clk);
    sb.check_leftover();
    if (!sb.failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/xsks_pkg.sv
hdl/xorshift_keystream_byte_xor_top.sv
hdl/xsks_checker.sv
verif/xorshift_keystream_byte_xor_top_tb.sv
